### design/wft_pkg.sv
package wft_pkg;

  // fixed result field widths
  localparam int IDX_W = 6;
  localparam int CNT_W = 16;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // input request: one character or an end of word
  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
  } in_t;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOW  = 1'b1;

  // one result per non-empty word
  typedef struct packed {
    logic [IDX_W-1:0] entry_index;
    logic [CNT_W-1:0] count;
    logic             new_word;
    logic             table_full;
    logic             truncated;
  } out_t;

endpackage

### design/wft_ram.sv
module wft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/wft_collect.sv
module wft_collect #(
  parameter int WORD_LEN = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                char_vld,
  input  logic [7:0]                          ch,
  input  logic                                clr,
  output logic [WORD_LEN*8-1:0]               word,
  output logic [$clog2(WORD_LEN+1)-1:0]       len,
  output logic                                overlong
);

  localparam int LW = $clog2(WORD_LEN + 1);

  logic [WORD_LEN*8-1:0] word_r, word_nxt;
  logic [LW-1:0]         len_r, len_nxt;
  logic                  overlong_r, overlong_nxt;
  logic                  full;

  assign full = (len_r == LW'(WORD_LEN));

  // append a character, or note the overflow; clear at end of word
  always_comb begin
    word_nxt     = word_r;
    len_nxt      = len_r;
    overlong_nxt = overlong_r;
    if (clr) begin
      len_nxt      = '0;
      overlong_nxt = 1'b0;
    end else if (char_vld) begin
      if (full) begin
        overlong_nxt = 1'b1;
      end else begin
        for (int k = 0; k < WORD_LEN; k++) begin
          if (len_r == LW'(k)) begin
            word_nxt[k*8 +: 8] = ch;
          end
        end
        len_nxt = len_r + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      overlong_r <= 1'b0;
    end else begin
      len_r      <= len_nxt;
      overlong_r <= overlong_nxt;
    end
  end

  // character buffer is payload only
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word     = word_r;
  assign len      = len_r;
  assign overlong = overlong_r;

endmodule

### design/wft_search.sv
module wft_search #(
  parameter int MAX_WORDS = 64,
  parameter int WORD_LEN  = 20
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          start,
  input  logic [WORD_LEN*8-1:0]                         word,
  input  logic [$clog2(WORD_LEN+1)-1:0]                 len,
  input  logic                                          overlong,
  output logic                                          busy,
  output logic                                          done,
  output logic                                          ram_we,
  output logic [(MAX_WORDS > 1 ? $clog2(MAX_WORDS) : 1)-1:0] ram_waddr,
  output logic [wft_pkg::CNT_W+$clog2(WORD_LEN+1)+WORD_LEN*8-1:0] ram_wdata,
  output logic                                          ram_re,
  output logic [(MAX_WORDS > 1 ? $clog2(MAX_WORDS) : 1)-1:0] ram_raddr,
  input  logic [wft_pkg::CNT_W+$clog2(WORD_LEN+1)+WORD_LEN*8-1:0] ram_rdata,
  output logic                                          out_valid,
  output wft_pkg::out_t                                 out_data
);

  localparam int IW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int TW = $clog2(MAX_WORDS + 1);
  localparam int LW = $clog2(WORD_LEN + 1);
  localparam int WB = WORD_LEN * 8;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                  state_r, state_nxt;
  logic [TW-1:0]         total_r, total_nxt;
  logic [TW-1:0]         rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic                  out_valid_r, out_valid_nxt;
  wft_pkg::out_t         out_r, out_nxt;

  logic [WB-1:0]            row_word;
  logic [LW-1:0]            row_len;
  logic [wft_pkg::CNT_W-1:0] row_cnt, inc_cnt;
  logic                     hit, rd_more, miss_done;

  // unpack the row on the read port: {count, length, bytes}
  assign row_word = ram_rdata[WB-1:0];
  assign row_len  = ram_rdata[WB +: LW];
  assign row_cnt  = ram_rdata[WB+LW +: wft_pkg::CNT_W];
  assign inc_cnt  = (row_cnt == wft_pkg::COUNT_MAX) ? row_cnt
                                                     : row_cnt + wft_pkg::CNT_W'(1);

  // entry match: equal length and equal bytes within that length
  always_comb begin
    hit = cmp_vld_r && (row_len == len);
    for (int k = 0; k < WORD_LEN; k++) begin
      if ((LW'(k) < len) && (row_word[k*8 +: 8] != word[k*8 +: 8])) begin
        hit = 1'b0;
      end
    end
  end

  assign rd_more   = (rd_idx_r < total_r);
  assign miss_done = !rd_more && !hit;

  // scan sequencer: one read per cycle, compare in the cycle after each read
  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_vld_nxt   = 1'b0;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_re        = 1'b0;
    ram_raddr     = rd_idx_r[IW-1:0];
    ram_we        = 1'b0;
    ram_waddr     = cmp_idx_r;
    ram_wdata     = {inc_cnt, row_len, row_word};
    done          = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt  = S_SCAN;
          rd_idx_nxt = '0;
        end
      end
      S_SCAN: begin
        ram_re      = rd_more;
        cmp_vld_nxt = rd_more;
        cmp_idx_nxt = rd_idx_r[IW-1:0];
        if (rd_more) begin
          rd_idx_nxt = rd_idx_r + TW'(1);
        end
        out_nxt.truncated = overlong;
        if (hit) begin
          // known word: bump its count in place
          ram_we               = 1'b1;
          out_valid_nxt        = 1'b1;
          out_nxt.entry_index  = wft_pkg::IDX_W'(cmp_idx_r);
          out_nxt.count        = inc_cnt;
          out_nxt.new_word     = 1'b0;
          out_nxt.table_full   = 1'b0;
          done                 = 1'b1;
          state_nxt            = S_IDLE;
        end else if (miss_done) begin
          out_valid_nxt = 1'b1;
          done          = 1'b1;
          state_nxt     = S_IDLE;
          if (total_r < TW'(MAX_WORDS)) begin
            // new word: append at the end of the table
            ram_we              = 1'b1;
            ram_waddr           = total_r[IW-1:0];
            ram_wdata           = {wft_pkg::CNT_W'(1), len, word};
            total_nxt           = total_r + TW'(1);
            out_nxt.entry_index = wft_pkg::IDX_W'(total_r[IW-1:0]);
            out_nxt.count       = wft_pkg::CNT_W'(1);
            out_nxt.new_word    = 1'b1;
            out_nxt.table_full  = 1'b0;
          end else begin
            out_nxt.entry_index = '0;
            out_nxt.count       = '0;
            out_nxt.new_word    = 1'b0;
            out_nxt.table_full  = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // scan pointers and result payload
  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    out_r     <= out_nxt;
  end

  assign busy      = (state_r == S_SCAN);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### design/word_frequency_table_top.sv
// channel   ports                      direction  meaning
// request   start, busy, in_data       in/out     character or end of word; busy is the output
// result    out_valid, out_data        out        one-cycle strobe, no backpressure
//
// A character request leaves busy low.
// A non-empty end of word scans the table one entry per cycle through the
// word memory's read port; busy stays high until the entry at slot j matches,
// or until every entry is compared when the word is new or the table is full.
// The result appears for one cycle right after busy falls; an empty word gives none.
// Reset (rst_n low, synchronous) empties the table and the collected word;
// the memory needs no clearing pass.
module word_frequency_table_top #(
  parameter int MAX_WORDS = 64,
  parameter int WORD_LEN  = 20
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  wft_pkg::in_t   in_data,
  output logic           out_valid,
  output wft_pkg::out_t  out_data
);

  localparam int IW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int LW = $clog2(WORD_LEN + 1);
  localparam int RW = wft_pkg::CNT_W + LW + WORD_LEN * 8;

  logic                  accept, char_vld, eow, search_start, done;
  logic [WORD_LEN*8-1:0] word;
  logic [LW-1:0]         len;
  logic                  overlong, clr;
  logic                  ram_we, ram_re;
  logic [IW-1:0]         ram_waddr, ram_raddr;
  logic [RW-1:0]         ram_wdata, ram_rdata;

  // request decode
  assign accept       = start && !busy;
  assign char_vld     = accept && (in_data.kind == wft_pkg::KIND_CHAR);
  assign eow          = accept && (in_data.kind == wft_pkg::KIND_EOW);
  assign search_start = eow && (len != '0);
  assign clr          = done || (eow && (len == '0));

  wft_collect #(
    .WORD_LEN (WORD_LEN)
  ) u_collect (
    .clk      (clk),
    .rst_n    (rst_n),
    .char_vld (char_vld),
    .ch       (in_data.ch),
    .clr      (clr),
    .word     (word),
    .len      (len),
    .overlong (overlong)
  );

  wft_search #(
    .MAX_WORDS (MAX_WORDS),
    .WORD_LEN  (WORD_LEN)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (search_start),
    .word      (word),
    .len       (len),
    .overlong  (overlong),
    .busy      (busy),
    .done      (done),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // dictionary rows: {count, length, bytes}
  wft_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
